// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset masking
`define RBF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked implication shorthand
`define RBF_ASSERT_IMP(label, ante, cons, msg) \
  `RBF_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ----- rtl/core/rbf_pkg.sv -----
// shared types and constants of the radial brush falloff pipeline
package rbf_pkg;

  localparam int FRAC_BITS = 8;

  // configuration register indexes
  localparam logic [1:0] REG_SHAPE   = 2'd0;
  localparam logic [1:0] REG_RADIUS  = 2'd1;
  localparam logic [1:0] REG_TSTEP   = 2'd2;
  localparam logic [1:0] REG_CEILING = 2'd3;

  localparam logic [1:0] SHAPE_COSINE = 2'd1;

  // paint mode upper limit: 1.0, limited to the value field
  localparam int PAINT_ONE = 1 << FRAC_BITS;
  localparam logic [13:0] PAINT_CEIL = (PAINT_ONE > 16383) ? 14'h3FFF : 14'(PAINT_ONE);

  // divider depths
  localparam int RATIO_STEPS   = 33;
  localparam int FALLOFF_STEPS = 18;

  // start to strobe latency in cycles
  localparam int LATENCY = 3 + RATIO_STEPS + 1 + FALLOFF_STEPS + 3;

  // per-item data that rides alongside the dividers
  typedef struct packed {
    logic        op;
    logic [13:0] cur;
    logic        neg;
    logic [17:0] mag;
    logic        hit;
    logic        active;
    logic        zero_r;
  } rbf_side_t;

endpackage

// ----- rtl/core/rbf_ratio_div.sv -----
// pipelined restoring divider: floor(d2 * 2^32 / r2), one quotient bit per stage
module rbf_ratio_div import rbf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [36:0] num,
  input  logic [35:0] den,
  input  rbf_side_t   in_side,
  output logic        out_valid,
  output logic [32:0] quot,
  output rbf_side_t   out_side
);

  logic        v_r    [RATIO_STEPS];
  logic [37:0] rem_r  [RATIO_STEPS];
  logic [32:0] q_r    [RATIO_STEPS];
  logic [35:0] den_r  [RATIO_STEPS];
  rbf_side_t   side_r [RATIO_STEPS];

  for (genvar k = 0; k < RATIO_STEPS; k++) begin : g_step
    logic [37:0] sh;
    logic [35:0] dv;
    logic [32:0] qp;
    logic        vp;
    rbf_side_t   sp;
    logic        ge;

    // first step takes the integer bit, later steps shift in a zero
    if (k == 0) begin : g_first
      assign sh = {1'b0, num};
      assign dv = den;
      assign qp = '0;
      assign vp = in_valid;
      assign sp = in_side;
    end else begin : g_next
      assign sh = {rem_r[k-1][36:0], 1'b0};
      assign dv = den_r[k-1];
      assign qp = q_r[k-1];
      assign vp = v_r[k-1];
      assign sp = side_r[k-1];
    end

    assign ge = sh >= {2'b00, dv};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? (sh - {2'b00, dv}) : sh;
      q_r[k]    <= {qp[31:0], ge};
      den_r[k]  <= dv;
      side_r[k] <= sp;
    end
  end

  assign out_valid = v_r[RATIO_STEPS-1];
  assign quot      = q_r[RATIO_STEPS-1];
  assign out_side  = side_r[RATIO_STEPS-1];

endmodule

// ----- rtl/core/rbf_falloff_div.sv -----
// pipelined falloff 4(1-x^2)/(4+x^2) in Q1.16, one quotient bit per stage
module rbf_falloff_div import rbf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [32:0] x2,
  input  rbf_side_t   in_side,
  output logic        out_valid,
  output logic [16:0] falloff,
  output rbf_side_t   out_side
);

  localparam logic [32:0] ONE = 33'h1_0000_0000;

  logic [32:0] x2c;
  logic        v0_r;
  logic [36:0] rem0_r;
  logic [35:0] den0_r;
  rbf_side_t   side0_r;

  logic        v_r    [FALLOFF_STEPS];
  logic [36:0] rem_r  [FALLOFF_STEPS];
  logic [17:0] q_r    [FALLOFF_STEPS];
  logic [35:0] den_r  [FALLOFF_STEPS];
  rbf_side_t   side_r [FALLOFF_STEPS];

  // clamp ratio and set up numerator and denominator
  assign x2c = (x2 > ONE) ? ONE : x2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem0_r  <= {4'b0000, ONE - x2c};
    den0_r  <= 36'h4_0000_0000 + {3'b000, x2c};
    side0_r <= in_side;
  end

  for (genvar k = 0; k < FALLOFF_STEPS; k++) begin : g_step
    logic [36:0] sh;
    logic [35:0] dv;
    logic [17:0] qp;
    logic        vp;
    rbf_side_t   sp;
    logic        ge;

    if (k == 0) begin : g_first
      assign sh = {rem0_r[35:0], 1'b0};
      assign dv = den0_r;
      assign qp = '0;
      assign vp = v0_r;
      assign sp = side0_r;
    end else begin : g_next
      assign sh = {rem_r[k-1][35:0], 1'b0};
      assign dv = den_r[k-1];
      assign qp = q_r[k-1];
      assign vp = v_r[k-1];
      assign sp = side_r[k-1];
    end

    assign ge = sh >= {1'b0, dv};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? (sh - {1'b0, dv}) : sh;
      q_r[k]    <= {qp[16:0], ge};
      den_r[k]  <= dv;
      side_r[k] <= sp;
    end
  end

  assign out_valid = v_r[FALLOFF_STEPS-1];
  assign falloff   = q_r[FALLOFF_STEPS-1][16:0];
  assign out_side  = side_r[FALLOFF_STEPS-1];

endmodule

// ----- rtl/core/radial_brush_falloff_update.sv -----
// top level of the radial cosine-falloff brush vertex update pipeline
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-------------------------
//   input   | in_op, in_vertex_*, in_current_value,   | start && !busy
//           | in_brush_*, in_amount                   |
//   result  | out_new_value, out_in_brush             | out_valid, one cycle
//   config  | cfg_index, cfg_wdata                    | cfg_we
//
// one transaction accepted every cycle; busy is low except during reset
// result strobes after the front stages, the 33-bit ratio divider and the 18-bit
// falloff divider (one quotient bit per stage), the multiplier stages and the result register
// synchronous reset empties the pipeline and restores the register defaults
// the receiver cannot stall, so the pipeline never holds
module radial_brush_falloff_update import rbf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [17:0] in_vertex_x,
  input  logic [17:0] in_vertex_z,
  input  logic [13:0] in_current_value,
  input  logic [17:0] in_brush_x,
  input  logic [17:0] in_brush_z,
  input  logic signed [17:0] in_amount,
  output logic        out_valid,
  output logic [13:0] out_new_value,
  output logic        out_in_brush,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_wdata
);

  logic [1:0]  brush_shape_r;
  logic [17:0] brush_radius_r;
  logic [15:0] time_step_r;
  logic [13:0] height_ceiling_r;

  logic        accept;
  logic        s1_v_r, s2_v_r, s3_v_r;
  logic        s1_op_r, s2_op_r;
  logic [13:0] s1_cur_r, s2_cur_r;
  logic [17:0] s1_amt_r, s2_amt_r;
  logic [17:0] s1_dx_r, s1_dz_r;
  logic [35:0] s2_dx2_r, s2_dz2_r, s2_r2_r;
  logic [36:0] d2;
  logic        neg;
  logic [36:0] s3_d2_r;
  logic [35:0] s3_r2_r;
  rbf_side_t   s3_side_r;

  logic        rd_v;
  logic [32:0] rd_q;
  rbf_side_t   rd_side;
  logic [32:0] x2;

  logic        fd_v;
  logic [16:0] fd_c;
  rbf_side_t   fd_side;

  logic        m1_v_r, m2_v_r;
  logic [34:0] m1_p_r;
  logic [50:0] m2_p_r;
  rbf_side_t   m1_side_r, m2_side_r;

  logic [51:0] rounded;
  logic [19:0] dm;
  logic signed [21:0] sum;
  logic [13:0] ceil_v;
  logic [13:0] clamped;

  logic        out_valid_r;
  logic [13:0] out_new_value_r;
  logic        out_in_brush_r;

  assign busy   = !rst_n;
  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brush_shape_r    <= SHAPE_COSINE;
      brush_radius_r   <= 18'd2560;
      time_step_r      <= 16'd1092;
      height_ceiling_r <= 14'd9792;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHAPE:   brush_shape_r    <= cfg_wdata[1:0];
        REG_RADIUS:  brush_radius_r   <= cfg_wdata;
        REG_TSTEP:   time_step_r      <= cfg_wdata[15:0];
        REG_CEILING: height_ceiling_r <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // stage 1: absolute offsets from the brush centre
  always_ff @(posedge clk) begin
    s1_op_r  <= in_op;
    s1_cur_r <= in_current_value;
    s1_amt_r <= in_amount;
    s1_dx_r  <= (in_vertex_x >= in_brush_x) ? in_vertex_x - in_brush_x
                                            : in_brush_x - in_vertex_x;
    s1_dz_r  <= (in_vertex_z >= in_brush_z) ? in_vertex_z - in_brush_z
                                            : in_brush_z - in_vertex_z;
  end

  // stage 2: squares
  always_ff @(posedge clk) begin
    s2_op_r  <= s1_op_r;
    s2_cur_r <= s1_cur_r;
    s2_amt_r <= s1_amt_r;
    s2_dx2_r <= s1_dx_r * s1_dx_r;
    s2_dz2_r <= s1_dz_r * s1_dz_r;
    s2_r2_r  <= brush_radius_r * brush_radius_r;
  end

  // stage 3: distance sum, inside test, strength magnitude
  assign d2  = {1'b0, s2_dx2_r} + {1'b0, s2_dz2_r};
  assign neg = s2_amt_r[17];

  always_ff @(posedge clk) begin
    s3_d2_r          <= d2;
    s3_r2_r          <= s2_r2_r;
    s3_side_r.op     <= s2_op_r;
    s3_side_r.cur    <= s2_cur_r;
    s3_side_r.neg    <= neg;
    s3_side_r.mag    <= neg ? 18'(19'h40000 - {1'b0, s2_amt_r}) : s2_amt_r;
    s3_side_r.hit    <= d2 <= {1'b0, s2_r2_r};
    s3_side_r.active <= (d2 <= {1'b0, s2_r2_r}) && (brush_shape_r == SHAPE_COSINE);
    s3_side_r.zero_r <= s2_r2_r == '0;
  end

  rbf_ratio_div u_ratio (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s3_v_r),
    .num      (s3_d2_r),
    .den      (s3_r2_r),
    .in_side  (s3_side_r),
    .out_valid(rd_v),
    .quot     (rd_q),
    .out_side (rd_side)
  );

  // zero radius means the vertex sits on the centre
  assign x2 = rd_side.zero_r ? '0 : rd_q;

  rbf_falloff_div u_falloff (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (rd_v),
    .x2       (x2),
    .in_side  (rd_side),
    .out_valid(fd_v),
    .falloff  (fd_c),
    .out_side (fd_side)
  );

  // strength scaling, one multiplier per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else begin
      m1_v_r <= fd_v;
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    m1_p_r    <= fd_side.mag * fd_c;
    m1_side_r <= fd_side;
    m2_p_r    <= m1_p_r * time_step_r;
    m2_side_r <= m1_side_r;
  end

  // round, apply and clamp
  assign rounded = {1'b0, m2_p_r} + 52'h0_0000_8000_0000;
  assign dm      = rounded[51:32];
  assign sum     = m2_side_r.neg ? $signed({8'b0, m2_side_r.cur}) - $signed({2'b0, dm})
                                 : $signed({8'b0, m2_side_r.cur}) + $signed({2'b0, dm});
  assign ceil_v  = m2_side_r.op ? PAINT_CEIL : height_ceiling_r;

  always_comb begin
    if (sum < 0) begin
      clamped = '0;
    end else if (sum > $signed({8'b0, ceil_v})) begin
      clamped = ceil_v;
    end else begin
      clamped = sum[13:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_new_value_r <= m2_side_r.active ? clamped : m2_side_r.cur;
    out_in_brush_r  <= m2_side_r.hit;
  end

  assign out_valid     = out_valid_r;
  assign out_new_value = out_new_value_r;
  assign out_in_brush  = out_in_brush_r;

endmodule

// ----- rtl/core/rbf_checker.sv -----
// port-level checker for the brush update pipeline and its bind
`include "assert_macros.svh"

module rbf_checker import rbf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_op,
  input logic [13:0] in_current_value,
  input logic        out_valid,
  input logic [13:0] out_new_value,
  input logic        out_in_brush
);

  // every strobe traces back to an accepted transaction
  `RBF_ASSERT_IMP(a_strobe_has_source, out_valid, $past(start && !busy, LATENCY), "strobe without transaction")

  // out of brush values pass through untouched
  `RBF_ASSERT_IMP(a_outside_passes, out_valid && !out_in_brush, out_new_value == $past(in_current_value, LATENCY), "outside value changed")

  // paint results stay within 1.0 unless passed through
  `RBF_ASSERT_IMP(a_paint_limit, out_valid && out_in_brush && $past(in_op, LATENCY), (out_new_value <= PAINT_CEIL) || (out_new_value == $past(in_current_value, LATENCY)), "paint above 1.0")

  // never busy out of reset
  `RBF_ASSERT(a_not_busy, !busy, "busy outside reset")

endmodule

bind radial_brush_falloff_update rbf_checker u_rbf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_op           (in_op),
  .in_current_value(in_current_value),
  .out_valid       (out_valid),
  .out_new_value   (out_new_value),
  .out_in_brush    (out_in_brush)
);
